/* hdl/mde_pkg.sv */
// Package for the marker delimited extractor.
// Holds item and result types, register indexes, status codes and reset values.
// No dependencies.
package mde_pkg;

    typedef logic [0:0] t_cfg_idx;

    localparam t_cfg_idx CFG_START_MARKER = 1'b0;
    localparam t_cfg_idx CFG_END_MARKER   = 1'b1;

    localparam logic [63:0] START_MARKER_RST = 64'd5281388957146239828;
    localparam logic [63:0] END_MARKER_RST   = 64'd5281388957146236228;

    typedef logic [1:0] t_status;

    localparam t_status STAT_RUN       = 2'd0;
    localparam t_status STAT_END_FOUND = 2'd1;
    localparam t_status STAT_NO_START  = 2'd2;
    localparam t_status STAT_NO_END    = 2'd3;

    typedef enum logic [1:0] {
        MODE_HUNT    = 2'd0,
        MODE_PAYLOAD = 2'd1,
        MODE_DONE    = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_item;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        t_status     status;
        logic [31:0] start_offset;
        logic [31:0] payload_length;
        logic        last;
    } t_result;

endpackage

/* hdl/marker_delimited_extractor.sv */
// Top level of the marker delimited extractor: input register, configuration
// registers and result register around mde_scan. Depends on mde_pkg, mde_scan.
//
//  channel   dir   handshake                  payload
//  s_axis    in    s_axis_tvalid/tready       tdata byte, tlast end of stream
//  m_axis    out   m_axis_tvalid/tready       tdata byte/offset/length, tuser, tlast
//  cfg       in    i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
//
// One item per cycle; each item passes the input register and the scan logic,
// and any result that it yields is held in the result register. The result register is
// the only bound on rate: an item advances when it is empty or being taken.
// Synchronous reset clears the stream state and reloads both markers.
// A stalled result holds; the input side keeps one item waiting meanwhile.
module marker_delimited_extractor
    import mde_pkg::*;
#(
    parameter int MARKER_BYTES = 8,
    parameter int OFFSET_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [7:0] payload_byte, [39:8] start_offset,
                                        // [71:40] payload_length
    output logic [2:0]  m_axis_tuser,   // [0] payload_valid, [2:1] status
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_idx    i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic        r_in_vld;
    t_item       r_in;
    logic        r_out_vld;
    t_result     r_out;
    logic [63:0] r_start_marker;
    logic [63:0] r_end_marker;

    logic        adv;
    logic        have;
    t_result     res;

    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;
    assign o_cfg_ready   = 1'b1;

    mde_scan #(
        .MARKER_BYTES (MARKER_BYTES),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (adv),
        .i_item         (r_in),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_have         (have),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_end_marker   <= END_MARKER_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_MARKER: r_start_marker <= i_cfg_data;
                CFG_END_MARKER:   r_end_marker   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.data_byte  <= s_axis_tdata;
            r_in.stream_end <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && have) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && have) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out.payload_length, r_out.start_offset, r_out.payload_byte};
    assign m_axis_tuser  = {r_out.status, r_out.payload_valid};
    assign m_axis_tlast  = r_out.last;

endmodule

/* hdl/mde_scan.sv */
// Scan stage: byte window, marker compare, mode and stream positions.
// Produces at most one result per advanced item. Depends on mde_pkg.
module mde_scan
    import mde_pkg::*;
#(
    parameter int MARKER_BYTES = 8,
    parameter int OFFSET_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_item       i_item,
    input  logic [63:0] i_start_marker,
    input  logic [63:0] i_end_marker,
    output logic        o_have,
    output t_result     o_res
);

    localparam int WIN_W  = 8 * MARKER_BYTES;
    localparam int FILL_W = $clog2(MARKER_BYTES + 1);
    localparam logic [FILL_W-1:0]    FILL_FULL = FILL_W'(MARKER_BYTES);
    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [OFFSET_BITS:0]   MB_EXT  = (OFFSET_BITS + 1)'(MARKER_BYTES);

    logic [WIN_W-1:0]       r_win,    n_win;
    logic [FILL_W-1:0]      r_fill,   n_fill;
    t_mode                  r_mode,   n_mode;
    logic [OFFSET_BITS-1:0] r_pos,    n_pos;
    logic [OFFSET_BITS-1:0] r_pstart, n_pstart;

    logic [WIN_W+7:0]       win_cat;
    logic [WIN_W-1:0]       win_sh;
    logic                   full_before;
    logic                   full_after;
    logic                   start_hit;
    logic                   end_hit;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS:0]   pos_p1;
    logic [OFFSET_BITS:0]   end_off;
    logic [OFFSET_BITS:0]   len;
    logic                   fin;

    assign fin         = i_item.stream_end;
    assign win_cat     = {r_win, i_item.data_byte};
    assign win_sh      = win_cat[WIN_W-1:0];
    assign full_before = (r_fill == FILL_FULL);
    assign full_after  = full_before || (r_fill == FILL_FULL - FILL_W'(1));
    assign start_hit   = full_after && (win_sh == i_start_marker[WIN_W-1:0]);
    assign end_hit     = full_after && (win_sh == i_end_marker[WIN_W-1:0]);
    assign pos_inc     = (r_pos == POS_MAX) ? r_pos : r_pos + OFFSET_BITS'(1);
    assign pos_p1      = {1'b0, r_pos} + (OFFSET_BITS + 1)'(1);
    assign end_off     = (pos_p1 >= MB_EXT) ? pos_p1 - MB_EXT : '0;
    assign len         = (end_off > {1'b0, r_pstart}) ? end_off - {1'b0, r_pstart} : '0;

    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            MODE_HUNT: begin
                if (start_hit) begin
                    n_mode = MODE_PAYLOAD;
                end
            end
            MODE_PAYLOAD: begin
                if (end_hit) begin
                    n_mode = MODE_DONE;
                end
            end
            MODE_DONE: begin
                n_mode = MODE_DONE;
            end
            default: begin
                n_mode = MODE_HUNT;
            end
        endcase
        if (fin) begin
            n_mode = MODE_HUNT;
        end
    end

    always_comb begin
        n_win    = win_sh;
        n_fill   = full_before ? r_fill : r_fill + FILL_W'(1);
        n_pos    = pos_inc;
        n_pstart = r_pstart;
        o_have   = 1'b0;
        o_res    = '0;
        unique case (r_mode)
            MODE_HUNT: begin
                if (start_hit) begin
                    n_pstart = pos_inc;
                    n_win    = '0;
                    n_fill   = '0;
                    if (fin) begin
                        o_have             = 1'b1;
                        o_res.status       = STAT_NO_END;
                        o_res.start_offset = 32'(pos_inc);
                        o_res.last         = 1'b1;
                    end
                end else if (fin) begin
                    o_have       = 1'b1;
                    o_res.status = STAT_NO_START;
                    o_res.last   = 1'b1;
                end
            end
            MODE_PAYLOAD: begin
                if (full_before) begin
                    o_have              = 1'b1;
                    o_res.payload_valid = 1'b1;
                    o_res.payload_byte  = r_win[WIN_W-1 -: 8];
                    o_res.start_offset  = 32'(r_pstart);
                end
                if (end_hit) begin
                    o_have               = 1'b1;
                    o_res.status         = STAT_END_FOUND;
                    o_res.start_offset   = 32'(r_pstart);
                    o_res.payload_length = 32'(len);
                    o_res.last           = 1'b1;
                end else if (fin) begin
                    o_have             = 1'b1;
                    o_res.status       = STAT_NO_END;
                    o_res.start_offset = 32'(r_pstart);
                    o_res.last         = 1'b1;
                end
            end
            default: begin
                o_have = 1'b0;
            end
        endcase
        if (fin) begin
            n_win    = '0;
            n_fill   = '0;
            n_pos    = '0;
            n_pstart = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= '0;
            r_fill   <= '0;
            r_mode   <= MODE_HUNT;
            r_pos    <= '0;
            r_pstart <= '0;
        end else if (i_step) begin
            r_win    <= n_win;
            r_fill   <= n_fill;
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_pstart <= n_pstart;
        end
    end

endmodule

/* hdl/mde_checker.sv */
// Port-level checks for the marker delimited extractor, bound to the top level.
// Depends on mde_pkg and marker_delimited_extractor.
module mde_checker
    import mde_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_last_has_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[2:1] != STAT_RUN)
        else $error("final item without status");

    a_running_carries_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[0] && m_axis_tuser[2:1] == STAT_RUN)
        else $error("running item without payload byte");

    a_no_start_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:1] == STAT_NO_START
        |-> !m_axis_tuser[0] && m_axis_tdata[71:8] == 64'd0)
        else $error("missing start item carries data");

    a_length_only_on_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:1] != STAT_END_FOUND |-> m_axis_tdata[71:40] == 32'd0)
        else $error("length without end marker");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled item changed");

endmodule

bind marker_delimited_extractor mde_checker u_mde_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
